### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// A stalled beat must hold its payload into the next cycle.
`define ASSERT_HOLD(lbl, clk, rstn, vld, rdy, pay) \
  `ASSERT_PROP(lbl, clk, rstn, (vld && !rdy) |=> (vld && $stable(pay)))

`endif

### hw/rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;

  typedef enum logic [1:0] {
    ST_CODE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_END     = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_input;
  } byte_item_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    status_e        status;
  } cp_item_t;

  // Decode outcome of one byte beat: a result or none.
  typedef struct packed {
    logic     has_result;
    cp_item_t item;
  } dec_res_t;

endpackage

### hw/rtl/u8d_byte_if.sv
// ----------------------------------------------------------------------------
// u8d_byte_if
// Byte input channel: valid/ready plus one raw byte or an end marker.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

### hw/rtl/u8d_cp_if.sv
// ----------------------------------------------------------------------------
// u8d_cp_if
// Result channel: valid/ready plus code point and status.
// ----------------------------------------------------------------------------
interface u8d_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  status;

  modport source (output valid, output code_point, output status, input ready);
  modport sink   (input valid, input code_point, input status, output ready);
endinterface

### hw/rtl/u8d_in_stage.sv
// ----------------------------------------------------------------------------
// u8d_in_stage
// Input register: captures one byte beat, frees when the core takes it.
// ----------------------------------------------------------------------------
module u8d_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  u8d_pkg::byte_item_t in_item_i,
  output logic                in_ready_o,
  input  logic                take_i,
  output logic                valid_o,
  output u8d_pkg::byte_item_t item_o
);
  import u8d_pkg::*;

  logic       valid_q;
  logic       valid_d;
  byte_item_t item_q;
  logic       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

### hw/rtl/u8d_core.sv
// ----------------------------------------------------------------------------
// u8d_core
// Decode state (open sequence, partial value, end flag) and per-byte update.
// ----------------------------------------------------------------------------
module u8d_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  u8d_pkg::byte_item_t item_i,
  input  logic                step_i,
  output u8d_pkg::dec_res_t   res_o
);
  import u8d_pkg::*;

  logic [1:0]       rem_q, rem_d;
  logic [CpW-1:0]   part_q, part_d;
  logic             ended_q, ended_d;
  logic [ByteW-1:0] b;
  logic [CpW-1:0]   part_n;
  dec_res_t         res;

  assign b      = item_i.data_byte;
  assign part_n = {part_q[CpW-7:0], b[5:0]};

  always_comb begin
    res.has_result      = 1'b0;
    res.item.code_point = '0;
    res.item.status     = ST_CODE;
    rem_d               = rem_q;
    part_d              = part_q;
    ended_d             = ended_q;
    priority if (ended_q) begin
      res.has_result  = 1'b1;
      res.item.status = ST_END;
    end else if (item_i.end_of_input) begin
      ended_d         = 1'b1;
      res.has_result  = 1'b1;
      rem_d           = 2'd0;
      part_d          = '0;
      res.item.status = (rem_q != 2'd0) ? ST_INVALID : ST_END;
    end else if (rem_q == 2'd0) begin
      priority if (!b[7]) begin
        res.has_result      = 1'b1;
        res.item.code_point = {{(CpW-ByteW){1'b0}}, b};
      end else if (b[7:5] == 3'b110) begin
        rem_d  = 2'd1;
        part_d = {{(CpW-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        rem_d  = 2'd2;
        part_d = {{(CpW-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        rem_d  = 2'd3;
        part_d = {{(CpW-3){1'b0}}, b[2:0]};
      end else begin
        res.has_result  = 1'b1;
        res.item.status = ST_INVALID;
      end
    end else if (b[7:6] != 2'b10) begin
      // bad continuation: byte consumed, sequence dropped
      res.has_result  = 1'b1;
      res.item.status = ST_INVALID;
      rem_d           = 2'd0;
      part_d          = '0;
    end else begin
      rem_d = rem_q - 2'd1;
      if (rem_q == 2'd1) begin
        res.has_result      = 1'b1;
        res.item.code_point = part_n;
        part_d              = '0;
      end else begin
        part_d = part_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= 2'd0;
      part_q  <= '0;
      ended_q <= 1'b0;
    end else if (step_i) begin
      rem_q   <= rem_d;
      part_q  <= part_d;
      ended_q <= ended_d;
    end
  end

  assign res_o = res;
endmodule

### hw/rtl/u8d_out_stage.sv
// ----------------------------------------------------------------------------
// u8d_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module u8d_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  u8d_pkg::cp_item_t item_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output u8d_pkg::cp_item_t item_o,
  output logic              free_o
);
  import u8d_pkg::*;

  logic     valid_q;
  logic     valid_d;
  cp_item_t item_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign item_o      = item_q;
endmodule

### hw/rtl/utf8_byte_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Lenient UTF-8 decoder: one byte (or end marker) per beat in, at most one
// code point / status beat out.
// ----------------------------------------------------------------------------
// Channels: byte_i carries data_byte and end_of_input; cp_o carries a 21-bit
//   code_point and a 2-bit status (code point, invalid sequence, end of input).
// Every byte beat is registered on entry; the decode update runs between
//   that register and the result register.
// A byte that completes a result passes the input register and then the
//   result register to reach cp_o. Lead and middle sequence bytes give no beat.
// Throughput: one byte per cycle while results are taken, set by the state
//   update (bytes remaining, partial value, end flag).
// Stall: a waiting result sits in the output register; the input register
//   still moves bytes that give no result. When a staged byte gives a result
//   and cp_o is stalled, byte_i.ready drops until the result is taken.
// Reset (async, active low): both registers empty, no open sequence, end
//   flag clear. End of input is sticky until the next reset.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  u8d_byte_if.sink      byte_i,
  u8d_cp_if.source      cp_o
);
  import u8d_pkg::*;

  byte_item_t in_item;
  byte_item_t stg_item;
  logic       stg_valid;
  dec_res_t   res;
  cp_item_t   out_item;
  logic       out_free;
  logic       step;

  assign in_item.data_byte    = byte_i.data_byte;
  assign in_item.end_of_input = byte_i.end_of_input;

  // a beat leaves the input register when its result has a free slot,
  // or right away when it gives no result
  assign step = stg_valid && (!res.has_result || out_free);

  u8d_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_item_i  (in_item),
    .in_ready_o (byte_i.ready),
    .take_i     (step),
    .valid_o    (stg_valid),
    .item_o     (stg_item)
  );

  u8d_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (stg_item),
    .step_i (step),
    .res_o  (res)
  );

  u8d_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res.has_result),
    .item_i      (res.item),
    .out_ready_i (cp_o.ready),
    .out_valid_o (cp_o.valid),
    .item_o      (out_item),
    .free_o      (out_free)
  );

  assign cp_o.code_point = out_item.code_point;
  assign cp_o.status     = out_item.status;
endmodule

### hw/rtl/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [20:0] code_point_i,
  input logic [1:0]  status_i
);
  import u8d_pkg::*;

  logic end_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_seen_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && status_i == ST_END) begin
      end_seen_q <= 1'b1;
    end
  end

  `ASSERT_HOLD(a_cp_hold, clk_i, rst_ni, out_valid_i, out_ready_i, code_point_i)
  `ASSERT_HOLD(a_st_hold, clk_i, rst_ni, out_valid_i, out_ready_i, status_i)
  `ASSERT_PROP(a_err_zero, clk_i, rst_ni, (out_valid_i && status_i != ST_CODE) |-> (code_point_i == '0))
  `ASSERT_PROP(a_end_sticky, clk_i, rst_ni, (out_valid_i && end_seen_q) |-> (status_i == ST_END))
  `ASSERT_PROP(a_st_legal, clk_i, rst_ni, out_valid_i |-> (status_i != 2'd3))
endmodule

bind utf8_byte_stream_decoder u8d_checker u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (cp_o.valid),
  .out_ready_i  (cp_o.ready),
  .code_point_i (cp_o.code_point),
  .status_i     (cp_o.status)
);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 byte stream decoder. A driver feeds byte
// beats from a queue with random idle cycles, a monitor takes result beats
// with random backpressure, and an in-bench decoder predicts every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8d_pkg::*;

  // Least number of beats scheduled before the end marker: the directed
  // bytes plus the random stream.
  localparam int unsigned StreamBeats = 390;

  logic clk_i;
  logic rst_ni;

  u8d_byte_if byte_ch ();
  u8d_cp_if   cp_ch ();

  utf8_byte_stream_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_ch),
    .cp_o   (cp_ch)
  );

  // Byte beats still to send, oldest first; the head is what the driver
  // presents.
  byte_item_t byte_beats[$];
  // Predicted result beats, oldest first.
  cp_item_t   expected_cps[$];

  int unsigned beats_taken;
  int unsigned mismatches;

  // Decoder state mirrored in the bench.
  logic [1:0]     conts_left;
  logic [CpW-1:0] partial_cp;
  logic           seen_end;

  // Between these byte counts neither side idles, so the block also runs
  // back to back at full rate for a while.
  wire quiet = (beats_taken >= 180) && (beats_taken < 300);

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    byte_ch.valid        = 1'b0;
    byte_ch.data_byte    = '0;
    byte_ch.end_of_input = 1'b0;
    cp_ch.ready          = 1'b0;
    fork
      forever #6 clk_i = ~clk_i;
      begin
        repeat (10) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Predictor: decode one accepted byte beat, queue the result it causes.
  // --------------------------------------------------------------------------
  task automatic decode_beat(input byte_item_t beat);
    cp_item_t   res;
    logic [7:0] b;
    b              = beat.data_byte;
    res.code_point = '0;
    res.status     = ST_CODE;
    if (seen_end) begin
      // sticky: anything after the end gives only end status
      res.status = ST_END;
      expected_cps.push_back(res);
    end else if (beat.end_of_input) begin
      seen_end = 1'b1;
      if (conts_left != 2'd0) begin
        res.status = ST_INVALID;  // stream cut inside a sequence
      end else begin
        res.status = ST_END;
      end
      conts_left = 2'd0;
      partial_cp = '0;
      expected_cps.push_back(res);
    end else if (conts_left == 2'd0) begin
      if (!b[7]) begin
        res.code_point = {{(CpW-8){1'b0}}, b};
        expected_cps.push_back(res);
      end else if (b[7:5] == 3'b110) begin
        conts_left = 2'd1;
        partial_cp = {{(CpW-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        conts_left = 2'd2;
        partial_cp = {{(CpW-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        conts_left = 2'd3;
        partial_cp = {{(CpW-3){1'b0}}, b[2:0]};
      end else begin
        // stray continuation or 11111xxx lead
        res.status = ST_INVALID;
        expected_cps.push_back(res);
      end
    end else if (b[7:6] != 2'b10) begin
      // broken continuation: byte eaten, sequence dropped
      conts_left = 2'd0;
      partial_cp = '0;
      res.status = ST_INVALID;
      expected_cps.push_back(res);
    end else begin
      partial_cp = {partial_cp[CpW-7:0], b[5:0]};
      conts_left = conts_left - 2'd1;
      if (conts_left == 2'd0) begin
        res.code_point = partial_cp;
        partial_cp     = '0;
        expected_cps.push_back(res);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: holds a beat until it is taken, then maybe idles, then sends the
  // next one. Every signal gets one nonblocking update per edge at most.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_beat(byte_beats.pop_front());
        beats_taken <= beats_taken + 1;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (byte_beats.size() == 0 || (!quiet && $urandom_range(0, 99) < 17)) begin
          byte_ch.valid <= 1'b0;
        end else begin
          byte_ch.valid        <= 1'b1;
          byte_ch.data_byte    <= byte_beats[0].data_byte;
          byte_ch.end_of_input <= byte_beats[0].end_of_input;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each taken result against the oldest prediction, and
  // stalls the result channel at random.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cp_item_t want;
    if (rst_ni) begin
      if (cp_ch.valid && cp_ch.ready) begin
        if (expected_cps.size() == 0) begin
          report_mismatch($sformatf("unexpected beat cp=%h status=%0d",
                                    cp_ch.code_point, cp_ch.status));
        end else begin
          want = expected_cps.pop_front();
          if (cp_ch.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d",
                                      cp_ch.status, want.status));
          end
          if (cp_ch.code_point !== want.code_point) begin
            report_mismatch($sformatf("code_point %h, want %h",
                                      cp_ch.code_point, want.code_point));
          end
        end
      end
      cp_ch.ready <= quiet || ($urandom_range(0, 99) >= 17);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_beat(input logic [7:0] b, input logic eoi);
    byte_item_t it;
    it.data_byte    = b;
    it.end_of_input = eoi;
    byte_beats.push_back(it);
  endtask

  // Random lead byte of a sequence of len bytes; len 1 is plain ASCII.
  function automatic logic [7:0] lead_byte(input int unsigned len);
    case (len)
      2: begin
        lead_byte = {3'b110, 5'($urandom_range(0, 31))};
      end
      3: begin
        lead_byte = {4'b1110, 4'($urandom_range(0, 15))};
      end
      4: begin
        lead_byte = {5'b11110, 3'($urandom_range(0, 7))};
      end
      default: begin
        lead_byte = 8'($urandom_range(0, 127));
      end
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    cont_byte = {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    static logic [7:0] directed [24] = '{
      8'h00, 8'h7F,                          // ASCII extremes
      8'hC0, 8'h80, 8'hDF, 8'hBF,            // 2-byte, zero and all ones
      8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,  // 3-byte extremes
      8'hF7, 8'hBF, 8'hBF, 8'hBF,            // 4-byte, widest value
      8'h80, 8'hF8, 8'hFF,                   // bad leads
      8'hC2, 8'h41,                          // ASCII where continuation due
      8'hF4, 8'h8F, 8'hFF                    // bad byte deep in 4-byte
    };
    int unsigned kind;
    int unsigned len;
    int unsigned keep;

    conts_left   = 2'd0;
    partial_cp   = '0;
    seen_end     = 1'b0;
    beats_taken  = 0;
    mismatches   = 0;

    foreach (directed[i]) add_beat(directed[i], 1'b0);

    // Mostly well-formed sequences with random payload; the rest are
    // truncated sequences and raw noise bytes.
    while (byte_beats.size() < StreamBeats) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (kind < 85) begin
        add_beat(lead_byte(len), 1'b0);
        repeat (len - 1) add_beat(cont_byte(), 1'b0);
      end else if (kind < 93) begin
        len = $urandom_range(2, 4);
        add_beat(lead_byte(len), 1'b0);
        repeat ($urandom_range(0, len - 2)) add_beat(cont_byte(), 1'b0);
        if ($urandom_range(0, 1)) begin
          add_beat(8'($urandom_range(0, 127)), 1'b0);
        end else begin
          add_beat(8'($urandom_range(192, 255)), 1'b0);
        end
      end else begin
        add_beat(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    // End marker comes either inside an open sequence or on a boundary;
    // the seed picks which.
    if ($urandom_range(0, 1)) begin
      len  = $urandom_range(2, 4);
      keep = $urandom_range(0, len - 2);
      add_beat(lead_byte(len), 1'b0);
      repeat (keep) add_beat(cont_byte(), 1'b0);
    end
    add_beat(8'($urandom_range(0, 255)), 1'b1);
    // after the end everything must read back as end status
    repeat (10) add_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    @(posedge clk_i);
    while (!rst_ni || byte_beats.size() != 0 || expected_cps.size() != 0) begin
      @(posedge clk_i);
    end
    // then keep clocking to catch any stray result beat
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS utf8_byte_stream_decoder");
    end else begin
      $display("FAIL utf8_byte_stream_decoder");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL utf8_byte_stream_decoder");
    $finish;
  end

endmodule
